// File: rtl/lse_pkg.sv
// shared types, constants and helper functions for the lsb stego embedder
// no dependencies; used by every module of the block by scoped name
`default_nettype none

package lse_pkg;

	// carrier bytes passed through untouched before the hidden frame
	localparam int HEADER_BYTES = 54;

	localparam int BIT_COUNT_W = 35;

	// phase codes
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_EXT    = 3'd3;
	localparam logic [2:0] PH_SIZE   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_PASS   = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_MAGIC_WORD  = 3'd0;
	localparam logic [2:0] REG_MAGIC_LEN   = 3'd1;
	localparam logic [2:0] REG_EXTN_WORD   = 3'd2;
	localparam logic [2:0] REG_EXTN_LEN    = 3'd3;
	localparam logic [2:0] REG_SECRET_SIZE = 3'd4;

	localparam logic [3:0] MAGIC_LEN_RESET = 4'd2;

	typedef struct packed {
		logic [7:0] carrier_byte;
		logic [7:0] payload_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] stego_byte;
		logic       payload_taken;
		logic [2:0] phase_code;
	} out_item_t;

	typedef struct packed {
		logic [63:0] magic_word;
		logic [3:0]  magic_len;
		logic [63:0] extn_word;
		logic [3:0]  extn_len;
		logic [31:0] secret_size;
	} cfg_t;

	typedef struct packed {
		logic [2:0]             phase;
		logic [BIT_COUNT_W-1:0] bit_count;
		logic [7:0]             payload_shift;
	} step_state_t;

	// byte counts above eight saturate
	function automatic logic [3:0] clamp8(input logic [3:0] n);
		return (n > 4'd8) ? 4'd8 : n;
	endfunction

	// phase length in carrier bytes; passthrough has none
	function automatic logic [BIT_COUNT_W-1:0] phase_len(input logic [2:0] ph, input cfg_t c);
		logic [BIT_COUNT_W-1:0] len;
		case (ph)
			PH_HEADER: len = BIT_COUNT_W'(HEADER_BYTES);
			PH_MAGIC:  len = {{(BIT_COUNT_W-7){1'b0}}, clamp8(c.magic_len), 3'b000};
			PH_EXTLEN: len = BIT_COUNT_W'(32);
			PH_EXT:    len = {{(BIT_COUNT_W-7){1'b0}}, clamp8(c.extn_len), 3'b000};
			PH_SIZE:   len = BIT_COUNT_W'(32);
			PH_DATA:   len = {c.secret_size, 3'b000};
			default:   len = '0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lse_cfg_regs.sv
// configuration register file of the lsb stego embedder
// depends on lse_pkg for the register indexes and cfg_t
`default_nettype none

module lse_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data,
	output lse_pkg::cfg_t      cfg
);

	lse_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word  <= '0;
			cfg_q.magic_len   <= lse_pkg::MAGIC_LEN_RESET;
			cfg_q.extn_word   <= '0;
			cfg_q.extn_len    <= '0;
			cfg_q.secret_size <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lse_pkg::REG_MAGIC_WORD:  cfg_q.magic_word  <= cfg_data;
				lse_pkg::REG_MAGIC_LEN:   cfg_q.magic_len   <= cfg_data[3:0];
				lse_pkg::REG_EXTN_WORD:   cfg_q.extn_word   <= cfg_data;
				lse_pkg::REG_EXTN_LEN:    cfg_q.extn_len    <= cfg_data[3:0];
				lse_pkg::REG_SECRET_SIZE: cfg_q.secret_size <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/lse_frame_step.sv
// per-byte frame logic: phase skip, bit select, lsb insert and next state
// depends on lse_pkg for types, phase codes and phase_len
`default_nettype none

module lse_frame_step (
	input  wire lse_pkg::cfg_t        cfg,
	input  wire lse_pkg::step_state_t cur,
	input  wire lse_pkg::in_item_t    item,
	output lse_pkg::step_state_t      nxt,
	output lse_pkg::out_item_t        res
);

	logic [2:0]                      p0;
	logic [lse_pkg::BIT_COUNT_W-1:0] bc0;
	logic [2:0]                      ph;
	logic [lse_pkg::BIT_COUNT_W-1:0] bc;
	logic [lse_pkg::BIT_COUNT_W-1:0] len;
	logic [lse_pkg::BIT_COUNT_W-1:0] bc_inc;
	logic                            found;
	logic [5:0]                      pos;
	logic [31:0]                     ext_len32;
	logic [7:0]                      shift_n;
	logic                            bit_v;
	logic                            taken;

	always_comb begin
		p0  = item.frame_start ? lse_pkg::PH_HEADER : cur.phase;
		bc0 = item.frame_start ? '0 : cur.bit_count;
		if (p0 > lse_pkg::PH_PASS)
			p0 = lse_pkg::PH_PASS;

		// finished phase: jump to the next phase with a non-zero length
		ph    = p0;
		bc    = bc0;
		found = 1'b0;
		if (p0 != lse_pkg::PH_PASS && bc0 >= lse_pkg::phase_len(p0, cfg)) begin
			bc = '0;
			ph = lse_pkg::PH_PASS;
			for (int k = 1; k < 6; k++) begin
				if (!found && 3'(k) > p0 && lse_pkg::phase_len(3'(k), cfg) != '0) begin
					ph    = 3'(k);
					found = 1'b1;
				end
			end
		end

		len       = lse_pkg::phase_len(ph, cfg);
		pos       = bc[5:0];
		ext_len32 = {28'd0, lse_pkg::clamp8(cfg.extn_len)};
		shift_n   = cur.payload_shift;
		taken     = 1'b0;
		bit_v     = 1'b0;
		case (ph)
			lse_pkg::PH_MAGIC:  bit_v = cfg.magic_word[pos];
			lse_pkg::PH_EXTLEN: bit_v = ext_len32[pos[4:0]];
			lse_pkg::PH_EXT:    bit_v = cfg.extn_word[pos];
			lse_pkg::PH_SIZE:   bit_v = cfg.secret_size[pos[4:0]];
			lse_pkg::PH_DATA: begin
				// new data byte latched on its first carrier byte
				if (bc[2:0] == 3'd0) begin
					shift_n = item.payload_byte;
					taken   = 1'b1;
				end
				bit_v = shift_n[bc[2:0]];
			end
			default: bit_v = 1'b0;
		endcase

		if (ph == lse_pkg::PH_HEADER || ph == lse_pkg::PH_PASS)
			res.stego_byte = item.carrier_byte;
		else
			res.stego_byte = {item.carrier_byte[7:1], bit_v};
		res.payload_taken = taken;
		res.phase_code    = ph;

		bc_inc            = bc + lse_pkg::BIT_COUNT_W'(1);
		nxt.payload_shift = shift_n;
		if (ph != lse_pkg::PH_PASS) begin
			if (bc_inc >= len) begin
				nxt.phase     = ph + 3'd1;
				nxt.bit_count = '0;
			end else begin
				nxt.phase     = ph;
				nxt.bit_count = bc_inc;
			end
		end else begin
			nxt.phase     = ph;
			nxt.bit_count = bc;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lsb_stego_embedder_unit.sv
// top level of the lsb stego embedder: input register, frame logic, result register
// depends on lse_pkg, lse_cfg_regs and lse_frame_step
//
// usage
//  - carrier channel (carrier_valid/carrier_ready/carrier_item): one image byte
//    per transfer with the next secret byte and a frame_start flag
//  - stego channel (stego_valid/stego_ready/stego_item): one result per carrier
//    byte, in order, with the output byte, payload_taken and the phase code
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    always ready; write only while no carrier byte is in flight
//  - path: a carrier byte goes through the input register, then the result
//    register, which offers its result on the stego channel
//  - throughput: one byte per cycle while stego_ready is high; the frame state
//    is updated in the same cycle the byte moves from input to result register
//  - the first 54 bytes after frame_start pass unchanged, then one frame bit
//    goes into each byte's lsb, then bytes pass unchanged again
//  - reset: pipeline empty, header phase, count zero, magic_len two,
//    other registers zero
//  - stall: with stego_ready low the result holds; the input register takes one
//    more byte only if it was empty, then carrier_ready drops
`default_nettype none

module lsb_stego_embedder_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// carrier input channel
	input  wire logic               carrier_valid,
	output logic                    carrier_ready,
	input  wire lse_pkg::in_item_t  carrier_item,
	// stego output channel
	output logic                    stego_valid,
	input  wire logic               stego_ready,
	output lse_pkg::out_item_t      stego_item,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	lse_pkg::cfg_t        cfg;
	lse_pkg::step_state_t state_q;
	lse_pkg::step_state_t state_next;
	lse_pkg::in_item_t    item_s1;
	logic                 valid_s1;
	lse_pkg::out_item_t   item_s2;
	lse_pkg::out_item_t   result;
	logic                 valid_s2;
	logic                 advance;

	lse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lse_frame_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (result)
	);

	// byte in stage one moves on when the result register is free or drained
	assign advance       = valid_s1 && (!valid_s2 || stego_ready);
	assign carrier_ready = !valid_s1 || advance;
	assign stego_valid   = valid_s2;
	assign stego_item    = item_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (carrier_ready) begin
			valid_s1 <= carrier_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (carrier_valid && carrier_ready) begin
			item_s1 <= carrier_item;
		end
	end

	// frame state, updated once per byte that leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (stego_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= result;
		end
	end

endmodule

`default_nettype wire
